### sv/slec_pkg.sv
// ----------------------------------------------------------------------------
// slec_pkg
// Types, codes and reset values shared by the link exchange controller.
// ----------------------------------------------------------------------------
`default_nettype none

package slec_pkg;

    // Phase codes
    localparam logic [1:0] PH_READY     = 2'd0;
    localparam logic [1:0] PH_SENDING   = 2'd1;
    localparam logic [1:0] PH_RECEIVING = 2'd2;

    // Command codes
    localparam logic [1:0] CMD_POLL    = 2'd0;
    localparam logic [1:0] CMD_TX_DONE = 2'd1;
    localparam logic [1:0] CMD_START   = 2'd2;

    // Receive verdict codes
    localparam logic [1:0] RX_INCOMPLETE = 2'd0;
    localparam logic [1:0] RX_ERROR      = 2'd1;
    localparam logic [1:0] RX_VALID      = 2'd2;

    // Configuration register indexes
    localparam int CFG_INDEX_BITS = 3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IS_MASTER          = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MASTER_TIMEOUT_US  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SLAVE_TIMEOUT_US   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MASTER_RETRY_LIMIT = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SLAVE_RETRY_LIMIT  = 3'd4;

    // Configuration reset values
    localparam logic [31:0] MASTER_TIMEOUT_RESET = 32'd2000;
    localparam logic [31:0] SLAVE_TIMEOUT_RESET  = 32'd10000;
    localparam logic [7:0]  MASTER_RETRY_RESET   = 8'd50;
    localparam logic [7:0]  SLAVE_RETRY_RESET    = 8'd10;

    localparam int ID_BITS_DEFAULT = 8;

    typedef struct packed {
        logic        is_master;
        logic [31:0] master_timeout_us;
        logic [31:0] slave_timeout_us;
        logic [7:0]  master_retry_limit;
        logic [7:0]  slave_retry_limit;
    } slec_cfg_t;

    typedef struct packed {
        logic [CFG_INDEX_BITS-1:0] index;
        logic [31:0]               value;
    } slec_cfg_wr_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] now_us;
        logic [1:0]  rx_status;
        logic [7:0]  rx_transfer_id;
    } slec_item_t;

    typedef struct packed {
        logic       send_packet;
        logic       fresh_payload;
        logic [7:0] tx_transfer_id;
        logic       rx_restart;
        logic       rx_deliver;
        logic       rx_packet_ok;
        logic       repeat_seen;
        logic       timeout_seen;
        logic       link_reset;
        logic       link_up_event;
        logic       link_connected;
        logic [1:0] link_state;
    } slec_result_t;

endpackage

`default_nettype wire

### sv/slec_ifs.sv
// ----------------------------------------------------------------------------
// slec_ifs
// Valid/ready channels for items, results and configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface slec_item_if;
    import slec_pkg::*;
    logic       valid;
    logic       ready;
    slec_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface slec_result_if;
    import slec_pkg::*;
    logic         valid;
    logic         ready;
    slec_result_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface slec_cfg_if;
    import slec_pkg::*;
    logic         valid;
    logic         ready;
    slec_cfg_wr_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### sv/slec_cfg_regs.sv
// ----------------------------------------------------------------------------
// slec_cfg_regs
// Configuration register file; takes one write transaction per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module slec_cfg_regs (
    input  wire logic             clk,
    input  wire logic             rst_n,
    slec_cfg_if.sink              cfg,
    output slec_pkg::slec_cfg_t   regs
);
    import slec_pkg::*;

    slec_cfg_t regs_reg;
    slec_cfg_t regs_next;
    logic      wr;

    assign cfg.ready = 1'b1;
    assign wr        = cfg.valid && cfg.ready;

    always_comb
    begin
        regs_next = regs_reg;
        if (wr)
        begin
            unique case (cfg.data.index)
                REG_IS_MASTER:          regs_next.is_master = cfg.data.value[0];
                REG_MASTER_TIMEOUT_US:  regs_next.master_timeout_us = cfg.data.value;
                REG_SLAVE_TIMEOUT_US:   regs_next.slave_timeout_us = cfg.data.value;
                REG_MASTER_RETRY_LIMIT: regs_next.master_retry_limit = cfg.data.value[7:0];
                REG_SLAVE_RETRY_LIMIT:  regs_next.slave_retry_limit = cfg.data.value[7:0];
                default:                regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.is_master          <= 1'b0;
            regs_reg.master_timeout_us  <= MASTER_TIMEOUT_RESET;
            regs_reg.slave_timeout_us   <= SLAVE_TIMEOUT_RESET;
            regs_reg.master_retry_limit <= MASTER_RETRY_RESET;
            regs_reg.slave_retry_limit  <= SLAVE_RETRY_RESET;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

    assign regs = regs_reg;

endmodule

`default_nettype wire

### sv/slec_core.sv
// ----------------------------------------------------------------------------
// slec_core
// Link state and the single-pass update for one command.
// ----------------------------------------------------------------------------
`default_nettype none

module slec_core #(
    parameter int ID_BITS = slec_pkg::ID_BITS_DEFAULT
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire slec_pkg::slec_cfg_t   cfg,
    input  wire logic                  step,
    input  wire slec_pkg::slec_item_t  item,
    output slec_pkg::slec_result_t     res
);
    import slec_pkg::*;

    logic [1:0]         phase_reg,     phase_next;
    logic [7:0]         fail_cnt_reg,  fail_cnt_next;
    logic               connected_reg, connected_next;
    logic               refresh_reg,   refresh_next;
    logic [ID_BITS-1:0] last_id_reg,   last_id_next;
    logic [ID_BITS-1:0] tx_id_reg,     tx_id_next;
    logic [31:0]        listen_reg,    listen_next;

    logic [ID_BITS+7:0] rid_ext;
    logic [ID_BITS+7:0] txid_ext;
    logic [ID_BITS-1:0] rid;
    logic [31:0]        elapsed;
    logic [31:0]        tmo_limit;
    logic [7:0]         retry_limit;
    logic [8:0]         fail_cnt_inc;
    logic               do_send;
    logic               do_fail;

    // ids are kept modulo 2^ID_BITS, output is the low byte
    assign rid_ext      = {{ID_BITS{1'b0}}, item.rx_transfer_id};
    assign rid          = rid_ext[ID_BITS-1:0];
    assign elapsed      = item.now_us - listen_reg;
    assign tmo_limit    = cfg.is_master ? cfg.master_timeout_us : cfg.slave_timeout_us;
    assign retry_limit  = cfg.is_master ? cfg.master_retry_limit : cfg.slave_retry_limit;
    assign fail_cnt_inc = {1'b0, fail_cnt_reg} + 9'd1;
    assign txid_ext     = {8'd0, tx_id_next};

    always_comb
    begin
        phase_next     = phase_reg;
        fail_cnt_next  = fail_cnt_reg;
        connected_next = connected_reg;
        refresh_next   = refresh_reg;
        last_id_next   = last_id_reg;
        tx_id_next     = tx_id_reg;
        listen_next    = listen_reg;
        do_send        = 1'b0;
        do_fail        = 1'b0;
        res            = '0;

        unique case (item.command)
            CMD_START:
            begin
                if (cfg.is_master)
                begin
                    phase_next = PH_READY;
                end
                else
                begin
                    phase_next     = PH_RECEIVING;
                    listen_next    = item.now_us;
                    res.rx_restart = 1'b1;
                end
            end
            CMD_TX_DONE:
            begin
                phase_next  = PH_RECEIVING;
                listen_next = item.now_us;
            end
            CMD_POLL:
            begin
                if (phase_reg == PH_READY)
                begin
                    do_send = 1'b1;
                end
                else if (phase_reg == PH_RECEIVING)
                begin
                    unique case (item.rx_status)
                        RX_ERROR:
                        begin
                            do_fail = 1'b1;
                        end
                        RX_VALID:
                        begin
                            res.rx_packet_ok = 1'b1;
                            do_send          = 1'b1;
                            if (rid == last_id_reg)
                            begin
                                res.repeat_seen = 1'b1;
                            end
                            else
                            begin
                                last_id_next   = rid;
                                res.rx_deliver = 1'b1;
                                if (!connected_reg)
                                begin
                                    connected_next    = 1'b1;
                                    res.link_up_event = 1'b1;
                                end
                                refresh_next  = 1'b1;
                                fail_cnt_next = 8'd0;
                            end
                        end
                        default:
                        begin
                            // incomplete, or an unknown verdict
                            if (elapsed > tmo_limit)
                            begin
                                res.timeout_seen = 1'b1;
                                do_fail          = 1'b1;
                            end
                        end
                    endcase
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        if (do_fail)
        begin
            if (fail_cnt_inc > {1'b0, retry_limit})
            begin
                connected_next = 1'b0;
                refresh_next   = 1'b1;
                fail_cnt_next  = 8'd0;
                res.link_reset = 1'b1;
            end
            else
            begin
                fail_cnt_next = fail_cnt_inc[7:0];
            end
            if (cfg.is_master)
            begin
                phase_next = PH_READY;
            end
            else
            begin
                phase_next     = PH_RECEIVING;
                listen_next    = item.now_us;
                res.rx_restart = 1'b1;
            end
        end

        if (do_send)
        begin
            phase_next      = PH_SENDING;
            res.send_packet = 1'b1;
            if (refresh_next)
            begin
                refresh_next      = 1'b0;
                tx_id_next        = tx_id_reg + {{(ID_BITS-1){1'b0}}, 1'b1};
                res.fresh_payload = 1'b1;
            end
            res.tx_transfer_id = txid_ext[7:0];
        end

        res.link_connected = connected_next;
        res.link_state     = phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_RECEIVING;
            fail_cnt_reg  <= 8'd0;
            connected_reg <= 1'b0;
            refresh_reg   <= 1'b0;
            last_id_reg   <= '0;
            tx_id_reg     <= '0;
            listen_reg    <= 32'd0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            fail_cnt_reg  <= fail_cnt_next;
            connected_reg <= connected_next;
            refresh_reg   <= refresh_next;
            last_id_reg   <= last_id_next;
            tx_id_reg     <= tx_id_next;
            listen_reg    <= listen_next;
        end
    end

endmodule

`default_nettype wire

### sv/split_link_exchange_controller.sv
// ----------------------------------------------------------------------------
// split_link_exchange_controller
// Half-duplex link controller: input register, one-pass update, result register.
// Path: an accepted item is held in the input register; its update goes to the result register.
// Throughput: one item per cycle while results are taken; a held result stalls new items.
// Reset: phase receiving, counters, ids and flags cleared, registers at defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module split_link_exchange_controller #(
    parameter int ID_BITS = slec_pkg::ID_BITS_DEFAULT
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    slec_cfg_if.sink      cfg,
    slec_item_if.sink     item,
    slec_result_if.source result
);
    import slec_pkg::*;

    slec_cfg_t    regs;
    slec_item_t   item_data_reg;
    slec_result_t res_comb;
    slec_result_t res_data_reg;
    logic         item_valid_reg, item_valid_next;
    logic         res_valid_reg,  res_valid_next;
    logic         advance;
    logic         step;
    logic         item_take;

    slec_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    slec_core #(
        .ID_BITS (ID_BITS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (regs),
        .step  (step),
        .item  (item_data_reg),
        .res   (res_comb)
    );

    assign advance    = !res_valid_reg || result.ready;
    assign step       = item_valid_reg && advance;
    assign item.ready = !item_valid_reg || advance;
    assign item_take  = item.valid && item.ready;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (item_take)
        begin
            item_valid_next = 1'b1;
        end
        else if (step)
        begin
            item_valid_next = 1'b0;
        end
        res_valid_next = advance ? item_valid_reg : res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            item_data_reg <= item.data;
        end
        if (step)
        begin
            res_data_reg <= res_comb;
        end
    end

    assign result.valid = res_valid_reg;
    assign result.data  = res_data_reg;

    // a staged item always reaches the result register when it is free
    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && !res_valid_reg |=> res_valid_reg)
        else $error("staged item did not advance");

    a_idle_id: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_data_reg.send_packet |->
            res_data_reg.tx_transfer_id == 8'd0 && !res_data_reg.fresh_payload)
        else $error("transfer id or fresh flag without a send");

    a_link_up: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_data_reg.link_up_event |->
            res_data_reg.link_connected && res_data_reg.rx_deliver)
        else $error("link up without a delivered packet");

    a_link_reset: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_data_reg.link_reset |->
            !res_data_reg.link_connected && !res_data_reg.send_packet)
        else $error("link reset left the link connected");

endmodule

`default_nettype wire

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for split_link_exchange_controller. It drives the item channel
// with random gaps and configuration writes without gaps, and tracks the link
// state in a class of its own to work out each expected result. Results are
// checked in order, field by field. The run covers a directed opening, then
// random phases that cover master and slave sides and limit and timeout extremes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import slec_pkg::*;

    // Codes that the package leaves unnamed and the block must tolerate
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;
    localparam logic [1:0] RX_UNKNOWN  = 2'd3;

    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 4;

    // Tracks phase, retry count, ids and link state; queues expected results
    class exchange_tracker;
        slec_cfg_t    cfg;
        logic [1:0]   phase;
        logic [7:0]   fail_cnt;
        logic         connected;
        logic         refresh;
        logic [7:0]   last_id;
        logic [7:0]   tx_id;
        logic [31:0]  listen_t;
        slec_result_t nxt;
        slec_result_t due_results[$];
        int           fails;
        int           reports;

        function new();
            cfg.is_master          = 1'b0;
            cfg.master_timeout_us  = MASTER_TIMEOUT_RESET;
            cfg.slave_timeout_us   = SLAVE_TIMEOUT_RESET;
            cfg.master_retry_limit = MASTER_RETRY_RESET;
            cfg.slave_retry_limit  = SLAVE_RETRY_RESET;
            phase     = PH_RECEIVING;
            fail_cnt  = '0;
            connected = 1'b0;
            refresh   = 1'b0;
            last_id   = '0;
            tx_id     = '0;
            listen_t  = '0;
            fails     = 0;
            reports   = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [31:0] val);
            case (idx)
                REG_IS_MASTER:          cfg.is_master          = val[0];
                REG_MASTER_TIMEOUT_US:  cfg.master_timeout_us  = val;
                REG_SLAVE_TIMEOUT_US:   cfg.slave_timeout_us   = val;
                REG_MASTER_RETRY_LIMIT: cfg.master_retry_limit = val[7:0];
                REG_SLAVE_RETRY_LIMIT:  cfg.slave_retry_limit  = val[7:0];
                default: ;
            endcase
        endfunction

        function void start_send();
            phase = PH_SENDING;
            nxt.send_packet = 1'b1;
            if (refresh)
            begin
                refresh = 1'b0;
                tx_id = tx_id + 8'd1;
                nxt.fresh_payload = 1'b1;
            end
            nxt.tx_transfer_id = tx_id;
        endfunction

        function void relisten(logic [31:0] now);
            phase = PH_RECEIVING;
            listen_t = now;
            nxt.rx_restart = 1'b1;
        endfunction

        // count plus one is compared before storing, so the count never wraps
        function void count_failure(logic [31:0] now);
            logic [7:0] limit;
            logic [8:0] cnt;
            limit = cfg.is_master ? cfg.master_retry_limit : cfg.slave_retry_limit;
            cnt = {1'b0, fail_cnt} + 9'd1;
            if (cnt > {1'b0, limit})
            begin
                connected = 1'b0;
                refresh = 1'b1;
                fail_cnt = '0;
                nxt.link_reset = 1'b1;
            end
            else
            begin
                fail_cnt = cnt[7:0];
            end
            if (cfg.is_master)
                phase = PH_READY;
            else
                relisten(now);
        endfunction

        function void note_item(slec_item_t it);
            logic [31:0] tmo;
            logic [31:0] elapsed;
            nxt = '0;
            case (it.command)
                CMD_START:
                begin
                    if (cfg.is_master)
                        phase = PH_READY;
                    else
                        relisten(it.now_us);
                end
                CMD_TX_DONE:
                begin
                    phase = PH_RECEIVING;
                    listen_t = it.now_us;
                end
                CMD_POLL:
                begin
                    if (phase == PH_READY)
                    begin
                        start_send();
                    end
                    else if (phase == PH_RECEIVING)
                    begin
                        if (it.rx_status == RX_ERROR)
                        begin
                            count_failure(it.now_us);
                        end
                        else if (it.rx_status == RX_VALID)
                        begin
                            nxt.rx_packet_ok = 1'b1;
                            if (it.rx_transfer_id == last_id)
                            begin
                                nxt.repeat_seen = 1'b1;
                                start_send();
                            end
                            else
                            begin
                                last_id = it.rx_transfer_id;
                                nxt.rx_deliver = 1'b1;
                                if (!connected)
                                begin
                                    connected = 1'b1;
                                    nxt.link_up_event = 1'b1;
                                end
                                refresh = 1'b1;
                                fail_cnt = '0;
                                start_send();
                            end
                        end
                        else
                        begin
                            // incomplete or unknown verdict: wrap-safe timeout test
                            tmo = cfg.is_master ? cfg.master_timeout_us
                                                : cfg.slave_timeout_us;
                            elapsed = it.now_us - listen_t;
                            if (elapsed > tmo)
                            begin
                                nxt.timeout_seen = 1'b1;
                                count_failure(it.now_us);
                            end
                        end
                    end
                end
                default: ;
            endcase
            nxt.link_connected = connected;
            nxt.link_state = phase;
            due_results.push_back(nxt);
        endfunction

        function string show(slec_result_t r);
            return $sformatf({"send=%0b fresh=%0b id=%0d restart=%0b deliver=%0b ok=%0b ",
                              "rep=%0b tmo=%0b rst=%0b up=%0b conn=%0b state=%0d"},
                             r.send_packet, r.fresh_payload, r.tx_transfer_id,
                             r.rx_restart, r.rx_deliver, r.rx_packet_ok, r.repeat_seen,
                             r.timeout_seen, r.link_reset, r.link_up_event,
                             r.link_connected, r.link_state);
        endfunction

        function void check_result(slec_result_t got);
            slec_result_t want;
            string bad;
            if (due_results.size() == 0)
            begin
                fails++;
                if (reports < 10)
                    $display("unexpected result at %0t: %s", $realtime, show(got));
                reports++;
                return;
            end
            want = due_results.pop_front();
            bad = "";
            if (got.send_packet    !== want.send_packet)    bad = {bad, " send_packet"};
            if (got.fresh_payload  !== want.fresh_payload)  bad = {bad, " fresh_payload"};
            if (got.tx_transfer_id !== want.tx_transfer_id) bad = {bad, " tx_transfer_id"};
            if (got.rx_restart     !== want.rx_restart)     bad = {bad, " rx_restart"};
            if (got.rx_deliver     !== want.rx_deliver)     bad = {bad, " rx_deliver"};
            if (got.rx_packet_ok   !== want.rx_packet_ok)   bad = {bad, " rx_packet_ok"};
            if (got.repeat_seen    !== want.repeat_seen)    bad = {bad, " repeat_seen"};
            if (got.timeout_seen   !== want.timeout_seen)   bad = {bad, " timeout_seen"};
            if (got.link_reset     !== want.link_reset)     bad = {bad, " link_reset"};
            if (got.link_up_event  !== want.link_up_event)  bad = {bad, " link_up_event"};
            if (got.link_connected !== want.link_connected) bad = {bad, " link_connected"};
            if (got.link_state     !== want.link_state)     bad = {bad, " link_state"};
            if (bad != "")
            begin
                fails++;
                if (reports < 10)
                begin
                    $display("mismatch at %0t in%s", $realtime, bad);
                    $display("  exp: %s", show(want));
                    $display("  got: %s", show(got));
                end
                reports++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    slec_cfg_if    cfg_ch();
    slec_item_if   item_ch();
    slec_result_if result_ch();

    split_link_exchange_controller dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .item   (item_ch),
        .result (result_ch)
    );

    exchange_tracker sb;
    bit              quiet;
    bit              hold_req;
    logic [31:0]     clock_us;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("tb failed");
        $finish;
    end

    function automatic bit take_gap();
        return !quiet && ($urandom_range(0, 99) < 10);
    endfunction

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            result_ch.ready <= !take_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
            sb.check_result(result_ch.data);
    end

    function automatic slec_item_t mk(logic [1:0] cmd, logic [31:0] now,
                                      logic [1:0] status, logic [7:0] id);
        slec_item_t it;
        it.command = cmd;
        it.now_us = now;
        it.rx_status = status;
        it.rx_transfer_id = id;
        return it;
    endfunction

    // Mostly well-formed exchanges: tx-done follows a send, polls dominate
    function automatic slec_item_t make_item();
        slec_item_t  it;
        int          pick;
        logic [31:0] tmo;
        pick = $urandom_range(0, 99);
        if (sb.phase == PH_SENDING && pick < 80)
        begin
            it.command = CMD_TX_DONE;
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 78)
                it.command = CMD_POLL;
            else if (pick < 90)
                it.command = CMD_TX_DONE;
            else if (pick < 95)
                it.command = CMD_START;
            else
                it.command = CMD_UNKNOWN;
        end
        tmo = sb.cfg.is_master ? sb.cfg.master_timeout_us : sb.cfg.slave_timeout_us;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            clock_us = 32'hFFFF_FFFF - $urandom_range(0, 3000);
        else if (pick < 5)
            clock_us = $urandom();
        else if (tmo <= 100000)
            clock_us = clock_us + $urandom_range(0, tmo + tmo / 4 + 1);
        else
            clock_us = clock_us + $urandom_range(0, 50000);
        it.now_us = clock_us;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            it.rx_status = RX_VALID;
        else if (pick < 75)
            it.rx_status = RX_INCOMPLETE;
        else if (pick < 90)
            it.rx_status = RX_ERROR;
        else
            it.rx_status = RX_UNKNOWN;
        pick = $urandom_range(0, 99);
        if (it.rx_status == RX_VALID && pick < 25)
            it.rx_transfer_id = sb.last_id;
        else if (it.rx_status == RX_VALID && pick < 85)
            it.rx_transfer_id = sb.last_id + 8'd1;
        else
            it.rx_transfer_id = 8'($urandom());
        return it;
    endfunction

    // Leaves valid high; the next call or the caller lowers it
    task automatic send_item(slec_item_t it);
        while (take_gap())
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data <= it;
        do
            @(posedge clk);
        while (item_ch.ready !== 1'b1);
        sb.note_item(it);
    endtask

    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        while (sb.due_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(logic [CFG_INDEX_BITS-1:0] idx, logic [31:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data.index <= idx;
        cfg_ch.data.value <= val;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        sb.write_reg(idx, val);
    endtask

    task automatic program_regs(logic mst, logic [31:0] mt, logic [31:0] st,
                                logic [7:0] mr, logic [7:0] sr);
        cfg_write(REG_IS_MASTER, {31'd0, mst});
        cfg_write(REG_MASTER_TIMEOUT_US, mt);
        cfg_write(REG_SLAVE_TIMEOUT_US, st);
        cfg_write(REG_MASTER_RETRY_LIMIT, {24'd0, mr});
        cfg_write(REG_SLAVE_RETRY_LIMIT, {24'd0, sr});
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_phase(int n, logic mst, logic [31:0] mt, logic [31:0] st,
                             logic [7:0] mr, logic [7:0] sr, int hold_at, int pause_at);
        program_regs(mst, mt, st, mr, sr);
        for (int i = 0; i < n; i++)
        begin
            if (i == hold_at)
                hold_req = 1'b1;
            if (i == pause_at)
                wait_drained();
            send_item(make_item());
        end
        wait_drained();
    endtask

    initial
    begin
        item_ch.valid <= 1'b0;
        item_ch.data <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data <= '0;
        rst_n <= 1'b0;
        quiet = 1'b0;
        hold_req = 1'b0;
        clock_us = '0;
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, slave side at reset settings
        send_item(mk(CMD_POLL, 32'd0, RX_INCOMPLETE, 8'h00));       // poll before start
        send_item(mk(CMD_POLL, 32'd10001, RX_INCOMPLETE, 8'h00));   // just past timeout
        send_item(mk(CMD_UNKNOWN, 32'hFFFF_FFFF, RX_UNKNOWN, 8'hFF));
        send_item(mk(CMD_START, 32'd20000, RX_INCOMPLETE, 8'h00));
        send_item(mk(CMD_POLL, 32'd20010, RX_UNKNOWN, 8'h00));      // unknown verdict
        send_item(mk(CMD_POLL, 32'd20020, RX_VALID, 8'h00));        // repeated id
        send_item(mk(CMD_POLL, 32'd20030, RX_VALID, 8'h05));        // poll while sending
        send_item(mk(CMD_TX_DONE, 32'hFFFF_FFF0, RX_INCOMPLETE, 8'h00));
        send_item(mk(CMD_POLL, 32'h0000_0010, RX_INCOMPLETE, 8'h00)); // across the wrap
        send_item(mk(CMD_POLL, 32'h0000_2720, RX_INCOMPLETE, 8'h00)); // wrapped timeout
        send_item(mk(CMD_POLL, 32'h0000_2730, RX_ERROR, 8'h00));
        send_item(mk(CMD_POLL, 32'h0000_2740, RX_VALID, 8'hFF));    // link comes up
        send_item(mk(CMD_TX_DONE, 32'h0000_2800, RX_INCOMPLETE, 8'h00));
        send_item(mk(CMD_POLL, 32'h0000_2810, RX_VALID, 8'hFF));
        send_item(mk(CMD_TX_DONE, 32'h0000_2820, RX_ERROR, 8'h00));
        send_item(mk(CMD_POLL, 32'h0000_2900, RX_VALID, 8'h00));
        wait_drained();

        // Directed, master side with tightest limit and timeout
        program_regs(1'b1, 32'd1, SLAVE_TIMEOUT_RESET, 8'd0, SLAVE_RETRY_RESET);
        send_item(mk(CMD_START, 32'h0000_3000, RX_INCOMPLETE, 8'h00));
        send_item(mk(CMD_POLL, 32'h0000_3001, RX_ERROR, 8'h00));    // verdict ignored
        send_item(mk(CMD_TX_DONE, 32'h0000_3002, RX_INCOMPLETE, 8'h00));
        send_item(mk(CMD_POLL, 32'h0000_3003, RX_INCOMPLETE, 8'h00)); // equal, no timeout
        send_item(mk(CMD_POLL, 32'h0000_3005, RX_INCOMPLETE, 8'h00)); // link reset
        send_item(mk(CMD_POLL, 32'h0000_3006, RX_INCOMPLETE, 8'h00)); // fresh send
        send_item(mk(CMD_TX_DONE, 32'h0000_3007, RX_INCOMPLETE, 8'h00));
        send_item(mk(CMD_POLL, 32'h0000_3008, RX_VALID, 8'h7F));
        wait_drained();

        run_phase(190, 1'b0, 32'd300, 32'd200, 8'd4, 8'd3, -1, -1);
        quiet = 1'b1;
        run_phase(190, 1'b1, 32'd150, 32'd5000, 8'd2, 8'd7, -1, -1);
        quiet = 1'b0;
        run_phase(190, 1'b1, 32'd1, 32'hFFFF_FFFF, 8'd0, 8'd255, 60, -1);
        run_phase(190, 1'b0, 32'hFFFF_FFFF, 32'd1, 8'd255, 8'd0, -1, 95);
        run_phase(190, 1'b1, 32'hFFFF_FFFF, 32'd1000, 8'd255, 8'd5, -1, -1);
        run_phase(190, 1'b0, $urandom_range(1, 500), $urandom_range(1, 500),
                  8'($urandom_range(0, 6)), 8'($urandom_range(0, 6)), -1, -1);
        run_phase(190, 1'($urandom_range(0, 1)), $urandom_range(1, 500),
                  $urandom_range(1, 500), 8'($urandom_range(0, 6)),
                  8'($urandom_range(0, 6)), -1, -1);

        if (sb.fails == 0 && sb.due_results.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
